[hdl/ite_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_pkg
// shared types, constants and codes of the inductor track error estimator
// ----------------------------------------------------------------------------
package ite_pkg;

    localparam int CHANNELS              = 4;
    localparam int DEFAULT_WINDOW_LENGTH = 5;
    localparam int SAMPLE_W              = 8;
    localparam int LEVEL_W               = 7;
    localparam int ERR_W                 = 8;
    localparam int DIV_W                 = 15;
    localparam int DVS_W                 = 8;
    localparam int DIV_CNT_W             = 4;
    localparam int PROD_W                = 16;
    localparam int ROOT_W                = 8;
    localparam int ACC_W                 = 15;
    localparam int CFG_IDX_W             = 4;
    localparam int CFG_DATA_W            = 8;

    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [LEVEL_W-1:0]    t_level;
    typedef logic [DIV_W-1:0]      t_div_data;
    typedef logic [DVS_W-1:0]      t_divisor;
    typedef logic [DIV_CNT_W-1:0]  t_div_cnt;
    typedef logic [PROD_W-1:0]     t_prod;
    typedef logic [ROOT_W-1:0]     t_root;
    typedef logic [ACC_W-1:0]      t_acc;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [1:0]            t_chan;

    // level scale, thresholds of the bend rule, error gains and error limit
    localparam t_level LEVEL_TOP     = 7'd100;
    localparam t_level BEND_HIGH     = 7'd50;
    localparam t_level BEND_LOW      = 7'd30;
    localparam t_level BEND_LEFT_V   = 7'd22;
    localparam t_level BEND_RIGHT_V  = 7'd20;
    localparam t_sample GAIN_STRAIGHT = 8'd80;
    localparam t_sample GAIN_BEND     = 8'd100;
    localparam logic signed [ERR_W-1:0] ERR_LIMIT = 8'sd99;

    // register indexes
    localparam t_cfg_idx REG_LEFT_HORIZONTAL_MIN  = 4'd0;
    localparam t_cfg_idx REG_LEFT_VERTICAL_MIN    = 4'd1;
    localparam t_cfg_idx REG_RIGHT_VERTICAL_MIN   = 4'd2;
    localparam t_cfg_idx REG_RIGHT_HORIZONTAL_MIN = 4'd3;
    localparam t_cfg_idx REG_LEFT_HORIZONTAL_MAX  = 4'd4;
    localparam t_cfg_idx REG_LEFT_VERTICAL_MAX    = 4'd5;
    localparam t_cfg_idx REG_RIGHT_VERTICAL_MAX   = 4'd6;
    localparam t_cfg_idx REG_RIGHT_HORIZONTAL_MAX = 4'd7;

    localparam t_sample MIN_RESET [CHANNELS] = '{8'd4, 8'd1, 8'd0, 8'd4};
    localparam t_sample MAX_RESET [CHANNELS] = '{8'd232, 8'd235, 8'd235, 8'd234};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_NORM_MUL,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_SQRT_MUL,
        ST_SQRT_CMP,
        ST_ERR_MUL,
        ST_ERR_GO,
        ST_ERR_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_level                    left_horizontal_level;
        t_level                    left_vertical_level;
        t_level                    right_vertical_level;
        t_level                    right_horizontal_level;
        t_level                    left_magnitude;
        t_level                    right_magnitude;
        logic                      road_is_bend;
        logic signed [ERR_W-1:0]   steering_error;
    } t_result;

endpackage
`default_nettype wire

[hdl/ite_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_in_if
// sample channel: four raw inductor readings per beat
// ----------------------------------------------------------------------------
interface ite_in_if;
    logic             valid;
    logic             ready;
    ite_pkg::t_sample left_horizontal_sample;
    ite_pkg::t_sample left_vertical_sample;
    ite_pkg::t_sample right_vertical_sample;
    ite_pkg::t_sample right_horizontal_sample;

    modport source (
        output valid, left_horizontal_sample, left_vertical_sample,
               right_vertical_sample, right_horizontal_sample,
        input  ready
    );
    modport sink (
        input  valid, left_horizontal_sample, left_vertical_sample,
               right_vertical_sample, right_horizontal_sample,
        output ready
    );
endinterface
`default_nettype wire

[hdl/ite_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_out_if
// result channel: levels, magnitudes, road class and steering error
// ----------------------------------------------------------------------------
interface ite_out_if;
    logic                    valid;
    logic                    ready;
    ite_pkg::t_level         left_horizontal_level;
    ite_pkg::t_level         left_vertical_level;
    ite_pkg::t_level         right_vertical_level;
    ite_pkg::t_level         right_horizontal_level;
    ite_pkg::t_level         left_magnitude;
    ite_pkg::t_level         right_magnitude;
    logic                    road_is_bend;
    logic signed [7:0]       steering_error;

    modport source (
        output valid, left_horizontal_level, left_vertical_level,
               right_vertical_level, right_horizontal_level,
               left_magnitude, right_magnitude, road_is_bend, steering_error,
        input  ready
    );
    modport sink (
        input  valid, left_horizontal_level, left_vertical_level,
               right_vertical_level, right_horizontal_level,
               left_magnitude, right_magnitude, road_is_bend, steering_error,
        output ready
    );
endinterface
`default_nettype wire

[hdl/ite_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ite_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  ite_pkg::t_div_data   i_dividend,
    input  ite_pkg::t_divisor    i_divisor,
    output logic                 o_busy,
    output logic                 o_done,
    output ite_pkg::t_div_data   o_quotient
);

    logic                r_busy;
    logic                r_done;
    ite_pkg::t_div_cnt   r_cnt;
    ite_pkg::t_div_data  r_quo;
    ite_pkg::t_divisor   r_rem;
    ite_pkg::t_divisor   r_dvs;

    logic [ite_pkg::DVS_W:0] trial;
    logic [ite_pkg::DVS_W:0] diff;
    logic                    fits;
    ite_pkg::t_divisor       n_rem;
    ite_pkg::t_div_data      n_quo;

    always_comb begin
        trial = {r_rem, r_quo[ite_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? diff[ite_pkg::DVS_W-1:0] : trial[ite_pkg::DVS_W-1:0];
        n_quo = {r_quo[ite_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ite_pkg::t_div_cnt'(ite_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

[hdl/inductor_track_error_estimator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inductor_track_error_estimator
// difference-over-sum track position from four inductor readings
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one beat of four raw 8-bit inductor samples; o_out returns
//   one beat per input beat with four normalized levels (0..100), the left
//   and right magnitudes, the bend flag and the signed steering error.
//   the user writes calibration min/max registers through i_cfg_we/index/data
//   while the block is idle, which is not enforced; indexes above 7 are ignored.
// timing:
//   the next beat is taken only after the result has been loaded into the
//   output register and the sequencer is back in idle. the shared
//   1-bit-per-cycle divider (up to five divides) and the 8-step square root,
//   run twice on the shared 8x8 multiplier, set the time per beat; window
//   averages use a reciprocal multiply. a channel at or below its min, or
//   with a zero max, skips its divide. i_in.ready is high only in idle.
// reset:
//   synchronous, active low; sample windows clear to zero (zeros count in
//   the first averages) and calibration registers take their defaults.
// stall:
//   the result sits in an output register; the next beat may be accepted
//   and worked on while it waits, and the sequencer holds its new result
//   until the old one has been taken.
// ----------------------------------------------------------------------------
module inductor_track_error_estimator #(
    parameter int WINDOW_LENGTH = ite_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    ite_in_if.sink              i_in,
    ite_out_if.source           o_out,
    input  wire                 i_cfg_we,
    input  ite_pkg::t_cfg_idx   i_cfg_index,
    input  ite_pkg::t_cfg_data  i_cfg_data
);

    localparam int TAP_N = WINDOW_LENGTH - 1;
    localparam int SUM_W = $clog2(WINDOW_LENGTH * 255 + 1);
    localparam ite_pkg::t_chan LAST_CH = ite_pkg::t_chan'(ite_pkg::CHANNELS - 1);

    // average = (sum * AVG_RECIP) >> AVG_SHIFT, exact for every window sum
    // since sum * rounding error stays below 2^AVG_SHIFT
    localparam int AVG_SHIFT  = 17;
    localparam int AVG_RECIP  = (2 ** AVG_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT;

    // sequencer
    ite_pkg::t_state r_state, n_state;
    ite_pkg::t_chan  r_ch, n_ch;
    logic            r_side, n_side;
    logic [2:0]      r_bit, n_bit;

    // sliding windows: previous samples plus their running sum
    ite_pkg::t_sample   r_tap [ite_pkg::CHANNELS][TAP_N];
    logic [SUM_W-1:0]   r_sum [ite_pkg::CHANNELS];
    logic [SUM_W-1:0]   r_tot [ite_pkg::CHANNELS];
    ite_pkg::t_sample   samp  [ite_pkg::CHANNELS];

    // calibration
    ite_pkg::t_sample   r_min [ite_pkg::CHANNELS];
    ite_pkg::t_sample   r_max [ite_pkg::CHANNELS];

    // working registers
    ite_pkg::t_sample   r_avg, n_avg;
    ite_pkg::t_prod     r_prod;
    ite_pkg::t_acc      r_acc, n_acc;
    ite_pkg::t_root     r_root, n_root;
    ite_pkg::t_level    r_lvl [ite_pkg::CHANNELS];
    ite_pkg::t_level    n_lvl [ite_pkg::CHANNELS];
    ite_pkg::t_level    r_mag [2];
    ite_pkg::t_level    n_mag [2];
    logic               r_bend, n_bend;
    logic signed [ite_pkg::ERR_W-1:0] r_err, n_err;

    // output register
    ite_pkg::t_result   r_res, n_res;
    logic               r_out_valid, n_out_valid;

    // shared units
    ite_pkg::t_sample   mul_a, mul_b;
    logic               div_start;
    ite_pkg::t_div_data div_dividend;
    ite_pkg::t_divisor  div_divisor;
    logic               div_busy;
    logic               div_done;
    ite_pkg::t_div_data div_q;

    // helpers
    logic               in_acc;
    logic               out_acc;
    logic               out_free;
    logic [AVG_PROD_W-1:0] avg_prod;
    ite_pkg::t_sample   cur_min;
    ite_pkg::t_sample   cur_max;
    logic               below;
    logic               max_zero;
    ite_pkg::t_level    norm_lvl;
    ite_pkg::t_root     trial;
    ite_pkg::t_root     root_new;
    ite_pkg::t_level    sq_h;
    ite_pkg::t_level    sq_v;
    ite_pkg::t_level    mag_l;
    ite_pkg::t_level    mag_r;
    logic               l_ge;
    ite_pkg::t_level    mag_diff;
    logic               bend;
    ite_pkg::t_sample   err_q;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_acc  = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign samp[0] = i_in.left_horizontal_sample;
    assign samp[1] = i_in.left_vertical_sample;
    assign samp[2] = i_in.right_vertical_sample;
    assign samp[3] = i_in.right_horizontal_sample;

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    ite_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // ------------------------------------------------------------------
    // sample windows: the sum for this beat is the running sum plus the
    // new sample; the oldest tap drops out of the running sum
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ite_pkg::CHANNELS; c++) begin
                r_sum[c] <= '0;
                for (int k = 0; k < TAP_N; k++) begin
                    r_tap[c][k] <= '0;
                end
            end
        end else if (in_acc) begin
            for (int c = 0; c < ite_pkg::CHANNELS; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(samp[c]) - SUM_W'(r_tap[c][0]);
                for (int k = 0; k < TAP_N - 1; k++) begin
                    r_tap[c][k] <= r_tap[c][k+1];
                end
                r_tap[c][TAP_N-1] <= samp[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int c = 0; c < ite_pkg::CHANNELS; c++) begin
                r_tot[c] <= r_sum[c] + SUM_W'(samp[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= ite_pkg::MIN_RESET;
            r_max <= ite_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ite_pkg::REG_LEFT_HORIZONTAL_MIN:  r_min[0] <= i_cfg_data;
                ite_pkg::REG_LEFT_VERTICAL_MIN:    r_min[1] <= i_cfg_data;
                ite_pkg::REG_RIGHT_VERTICAL_MIN:   r_min[2] <= i_cfg_data;
                ite_pkg::REG_RIGHT_HORIZONTAL_MIN: r_min[3] <= i_cfg_data;
                ite_pkg::REG_LEFT_HORIZONTAL_MAX:  r_max[0] <= i_cfg_data;
                ite_pkg::REG_LEFT_VERTICAL_MAX:    r_max[1] <= i_cfg_data;
                ite_pkg::REG_RIGHT_VERTICAL_MAX:   r_max[2] <= i_cfg_data;
                ite_pkg::REG_RIGHT_HORIZONTAL_MAX: r_max[3] <= i_cfg_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    always_comb begin
        // window average of the current channel
        avg_prod = AVG_PROD_W'(r_tot[r_ch]) * AVG_PROD_W'(AVG_RECIP);

        cur_min  = r_min[r_ch];
        cur_max  = r_max[r_ch];
        below    = (r_avg <= cur_min);
        max_zero = (cur_max == '0);
        // normalized level, clamped at the top of the scale
        norm_lvl = (div_q > ite_pkg::t_div_data'(ite_pkg::LEVEL_TOP))
                   ? ite_pkg::LEVEL_TOP : div_q[ite_pkg::LEVEL_W-1:0];

        // one bit of the root per compare
        trial    = r_root | (ite_pkg::t_root'(1) << r_bit);
        root_new = (r_prod <= ite_pkg::t_prod'(r_acc)) ? trial : r_root;

        // left side uses levels 0/1, right side 2/3
        sq_h = r_side ? r_lvl[3] : r_lvl[0];
        sq_v = r_side ? r_lvl[2] : r_lvl[1];

        mag_l    = r_mag[0];
        mag_r    = r_mag[1];
        l_ge     = (mag_l >= mag_r);
        mag_diff = l_ge ? (mag_l - mag_r) : (mag_r - mag_l);

        bend = (r_lvl[0] > ite_pkg::BEND_HIGH && r_lvl[3] < ite_pkg::BEND_LOW &&
                r_lvl[1] > ite_pkg::BEND_LEFT_V) ||
               (r_lvl[0] < ite_pkg::BEND_LOW && r_lvl[3] > ite_pkg::BEND_HIGH &&
                r_lvl[2] > ite_pkg::BEND_RIGHT_V);

        // error magnitude never reaches the gain, so 8 bits hold it
        err_q = div_q[ite_pkg::SAMPLE_W-1:0];
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ite_pkg::ST_IDLE: begin
                if (in_acc) n_state = ite_pkg::ST_AVG_GO;
            end
            ite_pkg::ST_AVG_GO:   n_state = ite_pkg::ST_NORM_MUL;
            ite_pkg::ST_NORM_MUL: begin
                if (below || max_zero) begin
                    n_state = (r_ch == LAST_CH) ? ite_pkg::ST_SQ_A : ite_pkg::ST_AVG_GO;
                end else begin
                    n_state = ite_pkg::ST_NORM_GO;
                end
            end
            ite_pkg::ST_NORM_GO:   n_state = ite_pkg::ST_NORM_WAIT;
            ite_pkg::ST_NORM_WAIT: begin
                if (div_done) begin
                    n_state = (r_ch == LAST_CH) ? ite_pkg::ST_SQ_A : ite_pkg::ST_AVG_GO;
                end
            end
            ite_pkg::ST_SQ_A:     n_state = ite_pkg::ST_SQ_B;
            ite_pkg::ST_SQ_B:     n_state = ite_pkg::ST_SQ_C;
            ite_pkg::ST_SQ_C:     n_state = ite_pkg::ST_SQRT_MUL;
            ite_pkg::ST_SQRT_MUL: n_state = ite_pkg::ST_SQRT_CMP;
            ite_pkg::ST_SQRT_CMP: begin
                if (r_bit == '0) begin
                    n_state = r_side ? ite_pkg::ST_ERR_MUL : ite_pkg::ST_SQ_A;
                end else begin
                    n_state = ite_pkg::ST_SQRT_MUL;
                end
            end
            ite_pkg::ST_ERR_MUL:  n_state = ite_pkg::ST_ERR_GO;
            ite_pkg::ST_ERR_GO:   n_state = ite_pkg::ST_ERR_WAIT;
            ite_pkg::ST_ERR_WAIT: begin
                if (div_done) n_state = ite_pkg::ST_DONE;
            end
            ite_pkg::ST_DONE: begin
                if (out_free) n_state = ite_pkg::ST_IDLE;
            end
            default: n_state = ite_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath control per state
    // ------------------------------------------------------------------
    always_comb begin
        n_ch         = r_ch;
        n_side       = r_side;
        n_bit        = r_bit;
        n_avg        = r_avg;
        n_acc        = r_acc;
        n_root       = r_root;
        n_lvl        = r_lvl;
        n_mag        = r_mag;
        n_bend       = r_bend;
        n_err        = r_err;
        n_res        = r_res;
        n_out_valid  = out_acc ? 1'b0 : r_out_valid;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        unique case (r_state)
            ite_pkg::ST_IDLE: begin
                if (in_acc) n_ch = '0;
            end
            ite_pkg::ST_AVG_GO: begin
                // an average of 8-bit samples fits 8 bits
                n_avg = avg_prod[AVG_SHIFT +: ite_pkg::SAMPLE_W];
            end
            ite_pkg::ST_NORM_MUL: begin
                mul_a = r_avg - cur_min;
                mul_b = ite_pkg::t_sample'(ite_pkg::LEVEL_TOP);
                if (below) begin
                    n_lvl[r_ch] = '0;
                    n_ch        = r_ch + 1'b1;
                end else if (max_zero) begin
                    n_lvl[r_ch] = ite_pkg::LEVEL_TOP;
                    n_ch        = r_ch + 1'b1;
                end
                n_side = 1'b0;
            end
            ite_pkg::ST_NORM_GO: begin
                div_start    = 1'b1;
                div_dividend = r_prod[ite_pkg::DIV_W-1:0];
                div_divisor  = cur_max;
            end
            ite_pkg::ST_NORM_WAIT: begin
                if (div_done) begin
                    n_lvl[r_ch] = norm_lvl;
                    n_ch        = r_ch + 1'b1;
                end
            end
            ite_pkg::ST_SQ_A: begin
                mul_a = ite_pkg::t_sample'(sq_h);
                mul_b = ite_pkg::t_sample'(sq_h);
            end
            ite_pkg::ST_SQ_B: begin
                n_acc = ite_pkg::t_acc'(r_prod);
                mul_a = ite_pkg::t_sample'(sq_v);
                mul_b = ite_pkg::t_sample'(sq_v);
            end
            ite_pkg::ST_SQ_C: begin
                n_acc  = r_acc + ite_pkg::t_acc'(r_prod);
                n_root = '0;
                n_bit  = 3'd7;
            end
            ite_pkg::ST_SQRT_MUL: begin
                mul_a = trial;
                mul_b = trial;
            end
            ite_pkg::ST_SQRT_CMP: begin
                n_root = root_new;
                if (r_bit == '0) begin
                    n_mag[r_side] = (root_new > ite_pkg::t_root'(ite_pkg::LEVEL_TOP))
                                    ? ite_pkg::LEVEL_TOP
                                    : root_new[ite_pkg::LEVEL_W-1:0];
                    n_side = 1'b1;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ite_pkg::ST_ERR_MUL: begin
                mul_a  = ite_pkg::t_sample'(mag_diff);
                mul_b  = bend ? ite_pkg::GAIN_BEND : ite_pkg::GAIN_STRAIGHT;
                n_bend = bend;
            end
            ite_pkg::ST_ERR_GO: begin
                div_start    = 1'b1;
                div_dividend = r_prod[ite_pkg::DIV_W-1:0];
                div_divisor  = ite_pkg::t_divisor'(mag_l) + ite_pkg::t_divisor'(mag_r)
                               + ite_pkg::t_divisor'(1);
            end
            ite_pkg::ST_ERR_WAIT: begin
                if (div_done) n_err = l_ge ? $signed(err_q) : -$signed(err_q);
            end
            ite_pkg::ST_DONE: begin
                if (out_free) begin
                    n_res.left_horizontal_level  = r_lvl[0];
                    n_res.left_vertical_level    = r_lvl[1];
                    n_res.right_vertical_level   = r_lvl[2];
                    n_res.right_horizontal_level = r_lvl[3];
                    n_res.left_magnitude         = r_mag[0];
                    n_res.right_magnitude        = r_mag[1];
                    n_res.road_is_bend           = r_bend;
                    n_res.steering_error         = r_err;
                    n_out_valid                  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ite_pkg::ST_IDLE;
            r_ch        <= '0;
            r_side      <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_side      <= n_side;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= ite_pkg::t_prod'(mul_a) * ite_pkg::t_prod'(mul_b);
        r_avg  <= n_avg;
        r_acc  <= n_acc;
        r_root <= n_root;
        r_lvl  <= n_lvl;
        r_mag  <= n_mag;
        r_bend <= n_bend;
        r_err  <= n_err;
        r_res  <= n_res;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign i_in.ready                   = (r_state == ite_pkg::ST_IDLE);
    assign o_out.valid                  = r_out_valid;
    assign o_out.left_horizontal_level  = r_res.left_horizontal_level;
    assign o_out.left_vertical_level    = r_res.left_vertical_level;
    assign o_out.right_vertical_level   = r_res.right_vertical_level;
    assign o_out.right_horizontal_level = r_res.right_horizontal_level;
    assign o_out.left_magnitude         = r_res.left_magnitude;
    assign o_out.right_magnitude        = r_res.right_magnitude;
    assign o_out.road_is_bend           = r_res.road_is_bend;
    assign o_out.steering_error         = r_res.steering_error;

`ifndef SYNTHESIS
    // divider is never restarted mid-division
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // an accepted beat starts with the first channel's average
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ite_pkg::ST_AVG_GO && r_ch == '0))
        else $error("accept did not start the channel sweep");

    // magnitudes stay on the level scale
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.left_magnitude <= ite_pkg::LEVEL_TOP &&
                         r_res.right_magnitude <= ite_pkg::LEVEL_TOP))
        else $error("magnitude above level scale");

    // error stays within plus or minus ERR_LIMIT
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.steering_error <= ite_pkg::ERR_LIMIT &&
                         r_res.steering_error >= -ite_pkg::ERR_LIMIT))
        else $error("steering error out of range");

    // a finished beat with a free output register is shown next cycle
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ite_pkg::ST_DONE && !r_out_valid)
        |=> (r_out_valid && r_state == ite_pkg::ST_IDLE))
        else $error("finished result not loaded");
`endif

endmodule
`default_nettype wire
